[rtl/core/command_frame_encoder_defines.svh]
// Assertion macros for the command frame encoder checker.
// Depends on nothing; macros need clk in scope, the hold macro rst_n too.
`ifndef COMMAND_FRAME_ENCODER_DEFINES_SVH
`define COMMAND_FRAME_ENCODER_DEFINES_SVH

// A stalled word must hold its payload until it is taken.
`define CFE_ASSERT_HOLD(lbl, vld, stl, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && (stl)) |=> ((vld) && $stable(sig))) \
        else $error("stalled word changed");

// A condition that must hold in the same cycle, checked during reset too.
`define CFE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("invariant violated");

// A condition that must hold in the next cycle, checked during reset too.
`define CFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/cfe_pkg.sv]
// Shared types and constants for the command frame encoder.
// Depends on nothing; used by every module of the block.
package cfe_pkg;

    localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
    localparam logic [7:0] START_CODE_A   = 8'h00;
    localparam logic [7:0] START_CODE_B   = 8'hFF;
    localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;
    localparam logic [7:0] DIR_HOST       = 8'hD4;
    localparam logic [7:0] MAX_CMD_LEN    = 8'd254;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic [7:0] cmd_length;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_last;
    } frame_item_t;

    typedef struct packed {
        logic       hdr;
        logic [7:0] lenf;
        logic [7:0] data;
        logic       tail;
        logic [7:0] dcs;
    } desc_t;

endpackage

[rtl/core/cfe_front.sv]
// Front end: accepts command bytes, tracks frame state and builds descriptors.
// Depends on cfe_pkg.
module cfe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cfe_pkg::cmd_item_t cmd_data,
    output logic              cmd_stall,
    input  logic              q_full,
    output logic              push,
    output cfe_pkg::desc_t    push_desc
);
    import cfe_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] data_sum_reg, data_sum_next;
    logic [7:0] len_sat, left_cur, left_new, sum_cur, sum_new, chk_base;
    logic       start, tail;

    always_comb
    begin
        if (cmd_data.cmd_length > MAX_CMD_LEN)
            len_sat = MAX_CMD_LEN;
        else if (cmd_data.cmd_length == 8'd0)
            len_sat = 8'd1;
        else
            len_sat = cmd_data.cmd_length;
        start    = !in_frame_reg;
        left_cur = start ? len_sat : bytes_left_reg;
        sum_cur  = start ? 8'd0 : data_sum_reg;
        sum_new  = sum_cur + cmd_data.cmd_byte;
        left_new = left_cur - 8'd1;
        tail     = (left_new == 8'd0);
        chk_base = DIR_HOST + sum_new;
    end

    assign cmd_stall = q_full;
    assign push      = cmd_valid && !q_full;

    always_comb
    begin
        push_desc.hdr  = start;
        push_desc.lenf = len_sat + 8'd1;
        push_desc.data = cmd_data.cmd_byte;
        push_desc.tail = tail;
        push_desc.dcs  = 8'd0 - chk_base;
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        data_sum_next   = data_sum_reg;
        if (push)
        begin
            in_frame_next   = !tail;
            bytes_left_next = left_new;
            data_sum_next   = tail ? 8'd0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
            data_sum_reg   <= 8'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            data_sum_reg   <= data_sum_next;
        end
    end

endmodule

[rtl/core/cfe_fifo.sv]
// Short descriptor queue between the front end and the byte sequencer.
// Depends on cfe_pkg.
module cfe_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cfe_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output cfe_pkg::desc_t head_desc
);
    import cfe_pkg::*;

    desc_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/cfe_back.sv]
// Back end: walks each descriptor through header, data and trailer bytes.
// Depends on cfe_pkg; drives the registered output word.
module cfe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  cfe_pkg::desc_t       head_desc,
    output logic                 pop,
    output logic                 frame_valid,
    output cfe_pkg::frame_item_t frame_data,
    input  logic                 frame_stall
);
    import cfe_pkg::*;

    localparam logic [3:0] STEP_PRE     = 4'd0;
    localparam logic [3:0] STEP_START_A = 4'd1;
    localparam logic [3:0] STEP_START_B = 4'd2;
    localparam logic [3:0] STEP_LEN     = 4'd3;
    localparam logic [3:0] STEP_LCS     = 4'd4;
    localparam logic [3:0] STEP_DIR     = 4'd5;
    localparam logic [3:0] STEP_DATA    = 4'd6;
    localparam logic [3:0] STEP_DCS     = 4'd7;
    localparam logic [3:0] STEP_POST    = 4'd8;

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    frame_item_t out_reg, out_next;
    logic [3:0]  cur_step;
    logic        load_ok, emit, item_done;
    logic [7:0]  sel_byte;

    assign load_ok   = !out_valid_reg || !frame_stall;
    assign emit      = head_valid && load_ok;
    assign cur_step  = busy_reg ? step_reg : (head_desc.hdr ? STEP_PRE : STEP_DATA);
    assign item_done = ((cur_step == STEP_DATA) && !head_desc.tail)
                       || (cur_step == STEP_POST);
    assign pop       = emit && item_done;

    always_comb
    begin
        unique case (cur_step) inside
            STEP_PRE, STEP_START_A, STEP_POST: sel_byte = PREAMBLE_BYTE;
            STEP_START_B: sel_byte = START_CODE_B;
            STEP_LEN:     sel_byte = head_desc.lenf;
            STEP_LCS:     sel_byte = 8'd0 - head_desc.lenf;
            STEP_DIR:     sel_byte = DIR_HOST;
            STEP_DATA:    sel_byte = head_desc.data;
            STEP_DCS:     sel_byte = head_desc.dcs;
            default:      sel_byte = POSTAMBLE_BYTE;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load_ok)
            out_valid_next = emit;
        if (emit)
        begin
            out_next.frame_byte = sel_byte;
            out_next.run_last   = item_done;
            out_next.frame_last = (cur_step == STEP_POST);
            busy_next           = !item_done;
            step_next           = cur_step + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_PRE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_reg;

endmodule

[rtl/core/command_frame_encoder.sv]
// Top level of the command frame encoder: front end, queue and byte sequencer.
// Depends on cfe_pkg, cfe_front, cfe_fifo and cfe_back.
//
//   channel   direction   word           handshake
//   cmd       in          cmd_item_t     cmd_valid / cmd_stall
//   frame     out         frame_item_t   frame_valid / frame_stall
//
// Each command byte yields a data byte, with preamble, start codes, length,
// length checksum and direction ahead of a frame's first and data checksum and
// postamble after its last; meanwhile the front end fills the four-entry queue.
// Reset is asynchronous and clears all frame state and the queue.
// cmd_stall rises only while the queue is full; frame_stall freezes the output.
module command_frame_encoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cfe_pkg::cmd_item_t   cmd_data,
    output logic                 cmd_stall,
    output logic                 frame_valid,
    output cfe_pkg::frame_item_t frame_data,
    input  logic                 frame_stall
);
    import cfe_pkg::*;

    logic  push, q_full, pop, head_valid;
    desc_t push_desc, head_desc;

    cfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_stall (cmd_stall),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    cfe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    cfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_data  (frame_data),
        .frame_stall (frame_stall)
    );

endmodule

[rtl/core/cfe_checker.sv]
// Port-level checks for the command frame encoder, bound to the top level.
// Depends on cfe_pkg and command_frame_encoder_defines.svh.
`include "command_frame_encoder_defines.svh"

module cfe_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input cfe_pkg::cmd_item_t   cmd_data,
    input logic                 cmd_stall,
    input logic                 frame_valid,
    input cfe_pkg::frame_item_t frame_data,
    input logic                 frame_stall
);
    import cfe_pkg::*;

    `CFE_ASSERT_HOLD(a_cmd_hold, cmd_valid, cmd_stall, cmd_data)
    `CFE_ASSERT_HOLD(a_frame_hold, frame_valid, frame_stall, frame_data)
    `CFE_ASSERT_NOW(a_close_word, frame_valid && frame_data.frame_last,
        frame_data.run_last && (frame_data.frame_byte == POSTAMBLE_BYTE))
    `CFE_ASSERT_NEXT(a_reset_idle, !rst_n, !frame_valid && !cmd_stall)

endmodule

bind command_frame_encoder cfe_checker u_cfe_checker (.*);

[tb/sv/command_frame_encoder_test.sv]
// Self-checking testbench for command_frame_encoder: drives command words in bursts,
// predicts every framed output word and compares them under random output stalls.
// Depends on cfe_pkg and the command_frame_encoder RTL.
module command_frame_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfe_pkg::*;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    cmd_item_t   cmd_data = '0;
    logic        cmd_stall;
    logic        frame_valid;
    frame_item_t frame_data;
    logic        frame_stall = 1'b0;

    wire cmd_taken = cmd_valid && !cmd_stall;

    cmd_item_t   pending_words[$];
    frame_item_t expected_frame[$];
    frame_item_t next_expected;
    int          mismatch_count = 0;

    logic        framing = 1'b0;
    logic [7:0]  bytes_to_go = 8'd0;
    logic [7:0]  running_sum = 8'd0;

    int          burst_left = 1;
    int          idle_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          word_total = 0;

    command_frame_encoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_data   (cmd_data),
        .cmd_stall  (cmd_stall),
        .frame_valid(frame_valid),
        .frame_data (frame_data),
        .frame_stall(frame_stall)
    );

    function automatic void emit_frame_word(logic [7:0] value, logic run_end, logic frame_end);
        frame_item_t w;
        w.frame_byte = value;
        w.run_last   = run_end;
        w.frame_last = frame_end;
        expected_frame.push_back(w);
    endfunction

    function automatic void predict_frame_words(cmd_item_t w);
        logic [7:0] cmd_len;
        logic [7:0] len_field;
        logic       closing;
        if (!framing)
        begin
            cmd_len = w.cmd_length;
            if (cmd_len > MAX_CMD_LEN)
                cmd_len = MAX_CMD_LEN;
            if (cmd_len == 8'd0)
                cmd_len = 8'd1;
            len_field = cmd_len + 8'd1;
            emit_frame_word(PREAMBLE_BYTE, 1'b0, 1'b0);
            emit_frame_word(START_CODE_A, 1'b0, 1'b0);
            emit_frame_word(START_CODE_B, 1'b0, 1'b0);
            emit_frame_word(len_field, 1'b0, 1'b0);
            emit_frame_word(8'd0 - len_field, 1'b0, 1'b0);
            emit_frame_word(DIR_HOST, 1'b0, 1'b0);
            framing     = 1'b1;
            bytes_to_go = cmd_len;
            running_sum = 8'd0;
        end
        running_sum = running_sum + w.cmd_byte;
        bytes_to_go = bytes_to_go - 8'd1;
        closing     = (bytes_to_go == 8'd0);
        emit_frame_word(w.cmd_byte, !closing, 1'b0);
        if (closing)
        begin
            emit_frame_word(8'd0 - (DIR_HOST + running_sum), 1'b0, 1'b0);
            emit_frame_word(POSTAMBLE_BYTE, 1'b1, 1'b1);
            framing     = 1'b0;
            running_sum = 8'd0;
        end
    endfunction

    // The first word carries the length code; later words carry a length that must be ignored.
    function automatic int queue_command(logic [7:0] len_code, logic [7:0] first_byte);
        cmd_item_t w;
        int        count;
        count = (len_code > MAX_CMD_LEN) ? int'(MAX_CMD_LEN)
                                         : ((len_code == 8'd0) ? 1 : int'(len_code));
        w.cmd_byte   = first_byte;
        w.cmd_length = len_code;
        pending_words.push_back(w);
        for (int i = 1; i < count; i++)
        begin
            w.cmd_byte = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0: w.cmd_length = 8'd0;
                1: w.cmd_length = 8'd255;
                default: w.cmd_length = 8'($urandom_range(0, 255));
            endcase
            pending_words.push_back(w);
        end
        return count;
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("command_frame_encoder: mismatch");
        $finish;
    end

    initial
    begin
        int len_pick;
        int len_code;
        word_total += queue_command(8'd1, 8'h00);
        word_total += queue_command(8'd0, 8'hFF);
        word_total += queue_command(8'd1, 8'hFF);
        word_total += queue_command(8'd2, 8'h80);
        word_total += queue_command(8'd3, 8'h7F);
        word_total += queue_command(8'd255, 8'h5A);
        while (word_total < 270)
        begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 6)
                len_code = 0;
            else if (len_pick < 60)
                len_code = $urandom_range(1, 4);
            else if (len_pick < 90)
                len_code = $urandom_range(5, 16);
            else
                len_code = $urandom_range(17, 60);
            word_total += queue_command(len_code[7:0], 8'($urandom_range(0, 255)));
        end

        @(negedge clk);
        while (!rst_n || pending_words.size() != 0 || cmd_valid || expected_frame.size() != 0)
            @(negedge clk);
        repeat (64) @(posedge clk);
        if (mismatch_count == 0 && expected_frame.size() == 0)
            $display("command_frame_encoder: match");
        else
            $display("command_frame_encoder: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_taken)
                predict_frame_words(cmd_data);
            if (!cmd_valid || cmd_taken)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cmd_valid <= 1'b1;
                    cmd_data  <= pending_words.pop_front();
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 160);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:   frame_stall <= 1'b0;
                STALL_RANDOM: frame_stall <= 1'($urandom_range(0, 1));
                STALL_HEAVY:  frame_stall <= ($urandom_range(0, 3) != 0);
                default:      frame_stall <= ~frame_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (expected_frame.size() == 0)
            begin
                $error("unexpected frame word: frame_byte %0h", frame_data.frame_byte);
                mismatch_count++;
            end
            else
            begin
                next_expected = expected_frame.pop_front();
                if (frame_data.frame_byte !== next_expected.frame_byte)
                begin
                    $error("frame_byte: expected %0h, got %0h",
                           next_expected.frame_byte, frame_data.frame_byte);
                    mismatch_count++;
                end
                if (frame_data.run_last !== next_expected.run_last)
                begin
                    $error("run_last: expected %0b, got %0b",
                           next_expected.run_last, frame_data.run_last);
                    mismatch_count++;
                end
                if (frame_data.frame_last !== next_expected.frame_last)
                begin
                    $error("frame_last: expected %0b, got %0b",
                           next_expected.frame_last, frame_data.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
